FILE: hdl/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Shared widths, item kinds and register indexes for the sorted table search.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned SLOT_W  = 10;
    localparam int unsigned POS_W   = 10;
    localparam int unsigned COUNT_W = 11;
    localparam int unsigned APB_DW  = 32;
    localparam int unsigned APB_AW  = 3;

    typedef enum logic {
        KIND_LOAD   = 1'b0,
        KIND_SEARCH = 1'b1
    } t_kind;

    // register index taken from paddr[2]
    localparam logic REG_ENTRY_COUNT = 1'b0;

endpackage

FILE: hdl/sts_mem.sv
// ----------------------------------------------------------------------------
// sts_mem
// Single-port table RAM, one write or one registered read per cycle.
// ----------------------------------------------------------------------------
module sts_mem
    import sts_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_addr,
    input  logic [VALUE_W-1:0] i_wdata,
    output logic [VALUE_W-1:0] o_rdata
);

    logic [VALUE_W-1:0] r_mem [DEPTH];
    logic [VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/sts_ctrl.sv
// ----------------------------------------------------------------------------
// sts_ctrl
// Search sequencer: midpoint probe, shared signed compare, bound update,
// result register toward the output channel.
// ----------------------------------------------------------------------------
module sts_ctrl
    import sts_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int BW    = 11
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [COUNT_W-1:0]        i_entry_count,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_kind,
    input  logic [SLOT_W-1:0]         i_slot,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_found,
    output logic [POS_W-1:0]          o_position,
    output logic                      o_mem_we,
    output logic [AW-1:0]             o_mem_addr,
    output logic [VALUE_W-1:0]        o_mem_wdata,
    input  logic [VALUE_W-1:0]        i_mem_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADDR,
        S_CMP,
        S_OUT
    } t_state;

    t_state                    r_state, n_state;
    logic [BW-1:0]             r_lo, n_lo;
    logic [BW-1:0]             r_hi, n_hi;
    logic [BW-1:0]             r_mid, n_mid;
    logic signed [VALUE_W-1:0] r_target, n_target;
    logic                      r_res_found, n_res_found;
    logic [POS_W-1:0]          r_res_pos, n_res_pos;
    logic                      r_out_valid, n_out_valid;
    logic                      r_found, n_found;
    logic [POS_W-1:0]          r_position, n_position;

    logic [BW-1:0]             mid;
    logic [BW-1:0]             count_sat;
    logic                      slot_ok;
    logic signed [VALUE_W-1:0] probe;

    assign mid       = r_lo + ((r_hi - BW'(1) - r_lo) >> 1);
    assign count_sat = (32'(i_entry_count) > 32'(DEPTH)) ? BW'(DEPTH) : BW'(i_entry_count);
    assign slot_ok   = (32'(i_slot) < 32'(DEPTH));
    assign probe     = $signed(i_mem_rdata);

    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_target    = r_target;
        n_res_found = r_res_found;
        n_res_pos   = r_res_pos;
        n_out_valid = r_out_valid;
        n_found     = r_found;
        n_position  = r_position;
        o_mem_we    = 1'b0;
        o_mem_addr  = AW'(i_slot);

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_kind == KIND_LOAD) begin
                        o_mem_we = slot_ok;
                    end else begin
                        n_target = i_value;
                        n_lo     = '0;
                        n_hi     = count_sat;
                        n_state  = S_ADDR;
                    end
                end
            end
            S_ADDR: begin
                o_mem_addr = AW'(mid);
                if (r_lo < r_hi) begin
                    n_mid   = mid;
                    n_state = S_CMP;
                end else begin
                    n_res_found = 1'b0;
                    n_res_pos   = '0;
                    n_state     = S_OUT;
                end
            end
            S_CMP: begin
                if (probe == r_target) begin
                    n_res_found = 1'b1;
                    n_res_pos   = POS_W'(r_mid);
                    n_state     = S_OUT;
                end else begin
                    if (probe > r_target) begin
                        n_hi = r_mid;
                    end else begin
                        n_lo = r_mid + BW'(1);
                    end
                    n_state = S_ADDR;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_found     = r_res_found;
                    n_position  = r_res_pos;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_target    <= n_target;
        r_res_found <= n_res_found;
        r_res_pos   <= n_res_pos;
        r_found     <= n_found;
        r_position  <= n_position;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_position  = r_position;
    assign o_mem_wdata = $unsigned(i_value);

`ifndef ASSERT_OFF
    a_mid_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_lo <= r_mid && r_mid < r_hi))
        else $error("probe index outside search range");

    a_cmp_after_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ($past(r_state) == S_ADDR))
        else $error("compare without a preceding read");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |-> (r_state == S_IDLE))
        else $error("table write during a search");

    a_search_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_kind == KIND_SEARCH)
            |=> (r_state == S_ADDR && r_lo == '0))
        else $error("search beat did not start a probe sequence");

    a_miss_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_position == '0))
        else $error("miss with nonzero position");
`endif

endmodule

FILE: hdl/sorted_table_binary_search.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Sorted signed table with load and binary search items, APB count register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries kind, slot and value.
//   A load beat writes value at slot and returns nothing; slots
//   at DEPTH or above are dropped. A search beat returns one output beat
//   (o_out_valid / i_out_stall) with found and position.
//   entry_count sits at APB address 0; set it only while the block is idle.
//   A search makes P probes, P <= floor(log2(count))+1; a hit ends at the
//   matching compare, a miss once the search range is empty.
//   Each probe is one registered table read and one signed compare.
//   Loads go back to back. o_in_stall is high from a search beat until its
//   result reaches the output register, so a search holds the input all
//   that time. The output register holds one result, so the next item
//   is taken while it waits; a second result waits in the sequencer while
//   i_out_stall is high.
//   Reset clears the count and control state; table contents stay undefined.
// ----------------------------------------------------------------------------
module sorted_table_binary_search
    import sts_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_kind,
    input  logic [SLOT_W-1:0]         i_slot,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_found,
    output logic [POS_W-1:0]          o_position,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_AW-1:0]         paddr,
    input  logic [APB_DW-1:0]         pwdata,
    output logic [APB_DW-1:0]         prdata,
    output logic                      pready
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BW = $clog2(DEPTH + 1);

    logic [COUNT_W-1:0] r_entry_count, n_entry_count;
    logic               cfg_wr;

    logic               mem_we;
    logic [AW-1:0]      mem_addr;
    logic [VALUE_W-1:0] mem_wdata;
    logic [VALUE_W-1:0] mem_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        n_entry_count = r_entry_count;
        if (cfg_wr && paddr[2] == REG_ENTRY_COUNT) begin
            n_entry_count = pwdata[COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else begin
            r_entry_count <= n_entry_count;
        end
    end

    assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? APB_DW'(r_entry_count) : '0;

    sts_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .BW    (BW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry_count (r_entry_count),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_slot        (i_slot),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_found       (o_found),
        .o_position    (o_position),
        .o_mem_we      (mem_we),
        .o_mem_addr    (mem_addr),
        .o_mem_wdata   (mem_wdata),
        .i_mem_rdata   (mem_rdata)
    );

    sts_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

endmodule

FILE: verif/tb_sorted_table_binary_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_table_binary_search
// Self-checking bench for the sorted table search: a directed table walk,
// then phases of sorted table loads followed by searches for present,
// neighboring, extreme and random targets. Each phase uses its own entry
// count and one of four idling mixes. An in-bench search model predicts
// each result beat that a directed row does not give itself. The model's
// state is kept in step with the bench's loads and register writes.
// ----------------------------------------------------------------------------
module tb_sorted_table_binary_search;
    import sts_pkg::*;

    localparam int DEPTH          = 1024;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_PHASES       = 8;
    localparam int SEARCHES       = 45;
    localparam int N_DIRECTED     = 22;

    localparam logic [APB_AW-1:0] COUNT_ADDR  = {REG_ENTRY_COUNT, 2'b00};
    localparam logic [APB_AW-1:0] UNUSED_ADDR = {~REG_ENTRY_COUNT, 2'b00};

    localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

    typedef struct {
        logic            found;
        logic [POS_W-1:0] position;
    } t_search_result;

    typedef struct {
        bit                cfg;
        logic [APB_AW-1:0] cfg_addr;
        logic [APB_DW-1:0] cfg_data;
        t_kind             kind;
        logic [SLOT_W-1:0] slot;
        logic [VALUE_W-1:0] value;
        bit                typed;
        logic              hit;
        logic [POS_W-1:0]  pos;
    } t_directed_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      o_in_stall;
    logic                      in_kind = 1'b0;
    logic [SLOT_W-1:0]         in_slot = '0;
    logic signed [VALUE_W-1:0] in_value = '0;
    logic                      o_out_valid;
    logic                      out_stall = 1'b0;
    logic                      o_found;
    logic [POS_W-1:0]          o_position;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [APB_AW-1:0]         paddr = '0;
    logic [APB_DW-1:0]         pwdata = '0;
    logic [APB_DW-1:0]         prdata;
    logic                      pready;

    logic signed [VALUE_W-1:0] table_shadow [DEPTH];
    logic [COUNT_W-1:0]        entry_count_q = '0;
    t_search_result            pending_results [$];
    t_search_result            got_want;

    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned n_errors = 0;
    int unsigned n_loads = 0;
    int unsigned n_searches = 0;
    int unsigned n_hits = 0;
    int unsigned n_reg_writes = 0;

    t_directed_row directed_rows [N_DIRECTED] = '{
        '{1'b1, COUNT_ADDR, 32'd0, KIND_SEARCH, 10'h3FF, 32'd0, 1'b1, 1'b0, 10'd0},
        '{1'b0, COUNT_ADDR, 32'd0, KIND_LOAD, 10'd0, VAL_MIN, 1'b0, 1'b0, 10'd0},
        '{1'b0, COUNT_ADDR, 32'd0, KIND_LOAD, 10'd1, -32'sd1000, 1'b0, 1'b0, 10'd0},
        '{1'b0, COUNT_ADDR, 32'd0, KIND_LOAD, 10'd2, -32'sd1, 1'b0, 1'b0, 10'd0},
        '{1'b0, COUNT_ADDR, 32'd0, KIND_LOAD, 10'd3, 32'd0, 1'b0, 1'b0, 10'd0},
        '{1'b0, COUNT_ADDR, 32'd0, KIND_LOAD, 10'd4, 32'd1, 1'b0, 1'b0, 10'd0},
        '{1'b0, COUNT_ADDR, 32'd0, KIND_LOAD, 10'd5, 32'd5, 1'b0, 1'b0, 10'd0},
        '{1'b0, COUNT_ADDR, 32'd0, KIND_LOAD, 10'd6, 32'd1000, 1'b0, 1'b0, 10'd0},
        '{1'b0, COUNT_ADDR, 32'd0, KIND_LOAD, 10'd7, VAL_MAX, 1'b0, 1'b0, 10'd0},
        '{1'b0, COUNT_ADDR, 32'd0, KIND_LOAD, 10'h3FF, 32'h5555_AAAA, 1'b0, 1'b0, 10'd0},
        '{1'b1, COUNT_ADDR, 32'd8, KIND_SEARCH, 10'd0, VAL_MIN, 1'b1, 1'b1, 10'd0},
        '{1'b0, COUNT_ADDR, 32'd0, KIND_SEARCH, 10'h2AA, VAL_MAX, 1'b1, 1'b1, 10'd7},
        '{1'b0, COUNT_ADDR, 32'd0, KIND_SEARCH, 10'h155, -32'sd1, 1'b1, 1'b1, 10'd2},
        '{1'b0, COUNT_ADDR, 32'd0, KIND_SEARCH, 10'd0, 32'd2, 1'b1, 1'b0, 10'd0},
        '{1'b0, COUNT_ADDR, 32'd0, KIND_SEARCH, 10'd0, VAL_MAX - 1, 1'b1, 1'b0, 10'd0},
        '{1'b0, COUNT_ADDR, 32'd0, KIND_SEARCH, 10'd0, VAL_MIN + 1, 1'b1, 1'b0, 10'd0},
        '{1'b1, UNUSED_ADDR, 32'd0, KIND_SEARCH, 10'd0, 32'd5, 1'b1, 1'b1, 10'd5},
        '{1'b1, COUNT_ADDR, 32'd1, KIND_SEARCH, 10'd0, VAL_MIN, 1'b1, 1'b1, 10'd0},
        '{1'b0, COUNT_ADDR, 32'd0, KIND_SEARCH, 10'd0, 32'd0, 1'b1, 1'b0, 10'd0},
        '{1'b0, COUNT_ADDR, 32'd0, KIND_LOAD, 10'd3, 32'd100, 1'b0, 1'b0, 10'd0},
        '{1'b1, COUNT_ADDR, 32'd8, KIND_SEARCH, 10'd0, 32'd100, 1'b0, 1'b0, 10'd0},
        '{1'b0, COUNT_ADDR, 32'd0, KIND_SEARCH, 10'd0, 32'd1, 1'b0, 1'b0, 10'd0}
    };

    sorted_table_binary_search uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_kind     (in_kind),
        .i_slot     (in_slot),
        .i_value    (in_value),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_found    (o_found),
        .o_position (o_position),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // binary search over the shadow table, saturated to DEPTH entries
    function automatic t_search_result bsearch_predict(input logic signed [VALUE_W-1:0] target);
        t_search_result r;
        int unsigned    lo;
        int unsigned    hi;
        int unsigned    mid;
        r.found    = 1'b0;
        r.position = '0;
        lo = 0;
        hi = (int'(entry_count_q) > DEPTH) ? DEPTH : int'(entry_count_q);
        while (lo < hi) begin
            mid = lo + (hi - 1 - lo) / 2;
            if (table_shadow[mid] == target) begin
                r.found    = 1'b1;
                r.position = mid[POS_W-1:0];
                return r;
            end
            if (table_shadow[mid] > target) hi = mid;
            else lo = mid + 1;
        end
        return r;
    endfunction

    task automatic push_beat(input t_kind k, input logic [SLOT_W-1:0] s,
                             input logic [VALUE_W-1:0] v, input bit typed = 1'b0,
                             input logic hit = 1'b0, input logic [POS_W-1:0] pos = '0);
        t_search_result r;
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_kind  <= k;
        in_slot  <= s;
        in_value <= v;
        do @(posedge i_clk); while (o_in_stall);
        if (k == KIND_LOAD) begin
            n_loads++;
            if (int'(s) < DEPTH) table_shadow[s] = v;
        end else begin
            n_searches++;
            r = bsearch_predict(v);
            if (typed) begin
                r.found    = hit;
                r.position = pos;
            end
            if (r.found) n_hits++;
            pending_results.push_back(r);
        end
    endtask

    // drop valid, drain results, then let in-flight loads finish
    task automatic settle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        logic [APB_DW-1:0] want;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        n_reg_writes++;
        if (addr == COUNT_ADDR) begin
            entry_count_q = data[COUNT_W-1:0];
            want = APB_DW'(entry_count_q);
            @(negedge i_clk);
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(negedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            if (prdata !== want) begin
                $error("entry_count readback: expected %0d, got %0d", want, prdata);
                n_errors++;
            end
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // n non-decreasing entries from slot 0 up; a full table spans both extremes
    task automatic load_ascending(input int unsigned n);
        longint      v;
        longint      max_step;
        int unsigned i;
        if (n == 0) return;
        max_step = (64'd4294967296 - 64'd2097152) / (n + 1);
        v = -64'sd2147483648 + longint'($urandom_range(1 << 20));
        if (n == DEPTH) v = -64'sd2147483648;
        for (i = 0; i < n; i++) begin
            if (i > 0) begin
                if ($urandom_range(9) != 0) v += longint'($urandom_range(32'(max_step), 1));
            end
            if (n == DEPTH && i == n - 1) v = 64'sd2147483647;
            push_beat(KIND_LOAD, i[SLOT_W-1:0], v[VALUE_W-1:0]);
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: found %0b position %0d",
                       o_found, o_position);
                n_errors++;
            end else begin
                got_want = pending_results.pop_front();
                if (o_found !== got_want.found) begin
                    $error("found: expected %0b, got %0b", got_want.found, o_found);
                    n_errors++;
                end
                if (o_position !== got_want.position) begin
                    $error("position: expected %0d, got %0d", got_want.position, o_position);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)
                    || (psel && penable && pready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
                $display("TEST FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        int unsigned phase_counts [N_PHASES];
        int unsigned ph;
        int unsigned span;
        int unsigned pick;
        int unsigned idx;
        int          d;
        logic [VALUE_W-1:0] target;

        phase_counts = '{1024, 2047, 64, 0, 1, 2, 5, 0};
        phase_counts[7] = $urandom_range(40, 3);

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (d = 0; d < N_DIRECTED; d++) begin
            if (directed_rows[d].cfg) begin
                settle();
                write_reg(directed_rows[d].cfg_addr, directed_rows[d].cfg_data);
            end
            push_beat(directed_rows[d].kind, directed_rows[d].slot, directed_rows[d].value,
                      directed_rows[d].typed, directed_rows[d].hit, directed_rows[d].pos);
        end
        settle();

        for (ph = 0; ph < N_PHASES; ph++) begin
            case (ph % 4)
                0: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct = 70;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 70;
                end
                default: begin
                    src_idle_pct = 23;
                    sink_stall_pct = 23;
                end
            endcase
            span = (phase_counts[ph] > DEPTH) ? DEPTH : phase_counts[ph];
            // count beyond depth reuses the full table from the phase before
            if (phase_counts[ph] <= DEPTH) load_ascending(span);
            settle();
            write_reg(COUNT_ADDR, phase_counts[ph]);
            if (ph == 2) hold_req = 1'b1;
            repeat (SEARCHES) begin
                pick = $urandom_range(99);
                if (pick < 6) begin
                    push_beat(KIND_LOAD, SLOT_W'($urandom_range(DEPTH - 1)), $urandom());
                end else begin
                    idx = (span == 0) ? 0 : $urandom_range(span - 1);
                    if (pick < 50 && span != 0) begin
                        target = table_shadow[idx];
                    end else if (pick < 70 && span != 0) begin
                        target = ($urandom_range(1) != 0) ? table_shadow[idx] + 1
                                                          : table_shadow[idx] - 1;
                    end else if (pick < 80) begin
                        case ($urandom_range(3))
                            0: target = VAL_MIN;
                            1: target = VAL_MAX;
                            2: target = '0;
                            default: target = '1;
                        endcase
                    end else begin
                        target = $urandom();
                    end
                    push_beat(KIND_SEARCH, SLOT_W'($urandom_range(DEPTH - 1)), target);
                end
            end
            settle();
        end

        $display("Covered %0d load beats and %0d searches (%0d hits) over %0d register writes,",
                 n_loads, n_searches, n_hits, n_reg_writes);
        $display("entry counts from empty to beyond depth, all idling mixes and a long output hold");
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
